@@ sv/tlvaks_pkg.sv @@
package tlvaks_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_KEY_HIGH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_KEY_LOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_KEY_HIGH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_KEY_LOW  = 8'd3;

  // Event codes of a result word.
  localparam logic [1:0] EV_FOUND     = 2'd0;
  localparam logic [1:0] EV_MALFORMED = 2'd1;
  localparam logic [1:0] EV_NO_MATCH  = 2'd2;
  localparam logic [1:0] EV_BAD_HDR   = 2'd3;

  // Record layout.
  localparam logic [4:0] KEY_HALF_BYTES = 5'd8;
  localparam logic [4:0] KEY_BYTES      = 5'd16;
  localparam logic [4:0] SIZE_BYTES     = 5'd4;
  localparam logic [4:0] LEN_BYTES      = 5'd8;
  localparam logic [31:0] VALUE_SIZE    = 32'd16;
  localparam int unsigned HDR_BYTES     = 20;

  // Result queue depth.
  localparam int unsigned RES_DEPTH = 4;

  // Parser phases.
  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_HKEY  = 8'b0000_0010,
    PH_HSIZE = 8'b0000_0100,
    PH_HDATA = 8'b0000_1000,
    PH_RKEY  = 8'b0001_0000,
    PH_RSIZE = 8'b0010_0000,
    PH_RDATA = 8'b0100_0000,
    PH_RVAL  = 8'b1000_0000
  } phase_t;

  // Key registers seen by the parser.
  typedef struct packed {
    logic [63:0] wanted_high;
    logic [63:0] wanted_low;
    logic [63:0] length_high;
    logic [63:0] length_low;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  code;
    logic [63:0] value_high;
    logic [63:0] value_low;
    logic        last;
  } res_t;

  // Pushes from the parser into the result queue.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

@@ sv/tlv_address_key_search.sv @@
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_data_byte, in_first_byte
// out     | output    | out_valid, out_ready, out_event_code, out_value_high, out_value_low,
//         |           | out_last_result
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One input byte is accepted per cycle while the result queue has room; it is decoded
// while it sits in the input register, and its result words are written into the result queue.
// Input flow stops only while the four-word result queue has fewer than two free slots.
// Synchronous active-low reset clears the parse state, the queue and the key registers.
// A stalled output holds the input side once three of the four queue slots are taken.
module tlv_address_key_search #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_first_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_event_code,
  output logic [63:0]                      out_value_high,
  output logic [63:0]                      out_value_low,
  output logic                             out_last_result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tlvaks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data
);
  import tlvaks_pkg::*;

  cfg_t  keys;
  push_t push;
  res_t  out_res;
  logic  res_room;

  tlvaks_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  tlvaks_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .keys          (keys),
    .res_room      (res_room),
    .push          (push)
  );

  tlvaks_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_room  (res_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_code  = out_res.code;
  assign out_value_high  = out_res.value_high;
  assign out_value_low   = out_res.value_low;
  assign out_last_result = out_res.last;

endmodule

@@ sv/tlvaks_cfg.sv @@
module tlvaks_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlvaks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  output tlvaks_pkg::cfg_t               keys
);
  import tlvaks_pkg::*;

  cfg_t keys_r;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ready = 1'b1;
  assign keys      = keys_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WANTED_KEY_HIGH: keys_r.wanted_high <= cfg_data;
        REG_WANTED_KEY_LOW:  keys_r.wanted_low  <= cfg_data;
        REG_LENGTH_KEY_HIGH: keys_r.length_high <= cfg_data;
        REG_LENGTH_KEY_LOW:  keys_r.length_low  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/tlvaks_parser.sv @@
module tlvaks_parser #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  input  tlvaks_pkg::cfg_t  keys,
  input  logic              res_room,
  output tlvaks_pkg::push_t push
);
  import tlvaks_pkg::*;

  // Input register.
  logic       st_valid_r;
  logic [7:0] st_byte_r;
  logic       st_first_r;
  logic       adv;

  // Parse state.
  phase_t                 phase_r,  phase_nxt;
  logic [OFFSET_BITS-1:0] off_r,    off_nxt;
  logic [4:0]             fc_r,     fc_nxt;
  logic [63:0]            ks_r,     ks_nxt;
  logic [31:0]            size_r,   size_nxt;
  logic [63:0]            tl_r,     tl_nxt;
  logic [31:0]            dr_r,     dr_nxt;
  logic                   match_r,  match_nxt;
  logic [63:0]            held_r,   held_nxt;

  // The byte in the input register moves on when the queue can take two words.
  assign adv      = st_valid_r && res_room;
  assign in_ready = !st_valid_r || res_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st_byte_r  <= in_data_byte;
      st_first_r <= in_first_byte;
    end
  end

  // Byte decode and state update.
  always_comb begin
    phase_t                 ph;
    logic [4:0]             fc_cur;
    logic [4:0]             fc_inc;
    logic [63:0]            ks_cur;
    logic [63:0]            ks_sh;
    logic                   m_cur;
    logic [OFFSET_BITS-1:0] off_cur;
    logic [63:0]            tl_cur;
    logic [31:0]            size_or;
    logic [31:0]            dr_dec;
    logic [64:0]            off_lim;
    logic                   bnd_end;
    logic                   emit_a;
    logic [1:0]             code_a;
    logic                   emit_b;
    logic [63:0]            val_hi;
    logic [63:0]            val_lo;

    phase_nxt = phase_r;
    off_nxt   = off_r;
    fc_nxt    = fc_r;
    ks_nxt    = ks_r;
    size_nxt  = size_r;
    tl_nxt    = tl_r;
    dr_nxt    = dr_r;
    match_nxt = match_r;
    held_nxt  = held_r;
    emit_a    = 1'b0;
    code_a    = EV_NO_MATCH;
    emit_b    = 1'b0;
    val_hi    = '0;
    val_lo    = '0;
    off_lim   = '0;
    bnd_end   = 1'b0;

    // A first byte restarts the blob at the first key byte.
    if (st_first_r) begin
      ph      = PH_HKEY;
      fc_cur  = '0;
      ks_cur  = '0;
      m_cur   = 1'b0;
      off_cur = '0;
      tl_cur  = '0;
    end else begin
      ph      = phase_r;
      fc_cur  = fc_r;
      ks_cur  = ks_r;
      m_cur   = match_r;
      off_cur = off_r;
      tl_cur  = tl_r;
    end

    fc_inc  = fc_cur + 5'd1;
    ks_sh   = {ks_cur[55:0], st_byte_r};
    size_or = size_r | (32'(st_byte_r) << {fc_cur[1:0], 3'b000});
    dr_dec  = dr_r - 32'd1;

    if (adv && (st_first_r || phase_r != PH_IDLE)) begin
      phase_nxt = ph;
      fc_nxt    = fc_cur;
      ks_nxt    = ks_cur;
      match_nxt = m_cur;
      tl_nxt    = tl_cur;
      off_nxt   = (off_cur == '1) ? off_cur : off_cur + 1'b1;

      // Total length ends the search if the next header would pass it.
      if (ph == PH_HDATA && fc_cur < LEN_BYTES) begin
        tl_nxt = tl_cur | (64'(st_byte_r) << {fc_cur[2:0], 3'b000});
      end
      off_lim = 65'(off_nxt) + 65'(HDR_BYTES);
      bnd_end = {1'b0, tl_nxt} < off_lim;

      case (ph)
        PH_HKEY, PH_RKEY: begin
          ks_nxt = ks_sh;
          fc_nxt = fc_inc;
          if (fc_inc == KEY_HALF_BYTES) begin
            match_nxt = (ph == PH_HKEY) ? (ks_sh == keys.length_high)
                                        : (ks_sh == keys.wanted_high);
            ks_nxt    = '0;
          end else if (fc_inc >= KEY_BYTES) begin
            match_nxt = m_cur && ((ph == PH_HKEY) ? (ks_sh == keys.length_low)
                                                  : (ks_sh == keys.wanted_low));
            ks_nxt    = '0;
            fc_nxt    = '0;
            size_nxt  = '0;
            phase_nxt = (ph == PH_HKEY) ? PH_HSIZE : PH_RSIZE;
          end
        end
        PH_HSIZE: begin
          size_nxt = size_or;
          fc_nxt   = fc_inc;
          if (fc_inc >= SIZE_BYTES) begin
            if (!m_cur || size_or == '0) begin
              emit_a    = 1'b1;
              code_a    = EV_BAD_HDR;
              phase_nxt = PH_IDLE;
            end else begin
              dr_nxt    = size_or;
              fc_nxt    = '0;
              tl_nxt    = '0;
              phase_nxt = PH_HDATA;
            end
          end
        end
        PH_HDATA: begin
          if (fc_cur < LEN_BYTES) begin
            fc_nxt = fc_inc;
          end
          dr_nxt = dr_dec;
          if (dr_dec == '0) begin
            if (bnd_end) begin
              emit_a    = 1'b1;
              code_a    = EV_NO_MATCH;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_RKEY;
              fc_nxt    = '0;
              ks_nxt    = '0;
              match_nxt = 1'b0;
            end
          end
        end
        PH_RSIZE: begin
          size_nxt = size_or;
          fc_nxt   = fc_inc;
          if (fc_inc >= SIZE_BYTES) begin
            if (m_cur && size_or == VALUE_SIZE) begin
              fc_nxt    = '0;
              ks_nxt    = '0;
              phase_nxt = PH_RVAL;
            end else begin
              dr_nxt = size_or;
              if (m_cur) begin
                emit_a = 1'b1;
                code_a = EV_MALFORMED;
              end
              if (size_or == '0) begin
                if (bnd_end) begin
                  // Malformed and end of search may land on one byte.
                  if (m_cur) begin
                    emit_b = 1'b1;
                  end else begin
                    emit_a = 1'b1;
                    code_a = EV_NO_MATCH;
                  end
                  phase_nxt = PH_IDLE;
                end else begin
                  phase_nxt = PH_RKEY;
                  fc_nxt    = '0;
                  ks_nxt    = '0;
                  match_nxt = 1'b0;
                end
              end else begin
                phase_nxt = PH_RDATA;
              end
            end
          end
        end
        PH_RDATA: begin
          dr_nxt = dr_dec;
          if (dr_dec == '0) begin
            if (bnd_end) begin
              emit_a    = 1'b1;
              code_a    = EV_NO_MATCH;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_RKEY;
              fc_nxt    = '0;
              ks_nxt    = '0;
              match_nxt = 1'b0;
            end
          end
        end
        PH_RVAL: begin
          ks_nxt = ks_sh;
          fc_nxt = fc_inc;
          if (fc_inc == KEY_HALF_BYTES) begin
            held_nxt = ks_sh;
            ks_nxt   = '0;
          end else if (fc_inc >= KEY_BYTES) begin
            emit_a    = 1'b1;
            code_a    = EV_FOUND;
            val_hi    = held_r;
            val_lo    = ks_sh;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // Result words for the queue.
    push.cnt               = {emit_b, emit_a && !emit_b};
    push.first.code        = code_a;
    push.first.value_high  = val_hi;
    push.first.value_low   = val_lo;
    push.first.last        = !emit_b;
    push.second.code       = EV_NO_MATCH;
    push.second.value_high = '0;
    push.second.value_low  = '0;
    push.second.last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      off_r   <= '0;
      fc_r    <= '0;
      ks_r    <= '0;
      size_r  <= '0;
      tl_r    <= '0;
      dr_r    <= '0;
      match_r <= 1'b0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      fc_r    <= fc_nxt;
      ks_r    <= ks_nxt;
      size_r  <= size_nxt;
      tl_r    <= tl_nxt;
      dr_r    <= dr_nxt;
      match_r <= match_nxt;
      held_r  <= held_nxt;
    end
  end

  function automatic logic ph_is_rsize();
    ph_is_rsize = (phase_r == PH_RSIZE) && !st_first_r;
  endfunction

  // A first byte always leaves the parser one byte into the header key.
  a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st_first_r) |=> (phase_r == PH_HKEY && fc_r == 5'd1))
    else $error("first byte did not restart the header key");

  // Two results on one byte are only a malformed record then end of search.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.first.code == EV_MALFORMED && ph_is_rsize()))
    else $error("unexpected result pair");

  // Results leave the parser idle unless the record was only malformed.
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0 && !(push.cnt == 2'd1 && push.first.code == EV_MALFORMED))
      |=> (phase_r == PH_IDLE))
    else $error("final result did not stop the search");

endmodule

@@ sv/tlvaks_res_fifo.sv @@
module tlvaks_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  tlvaks_pkg::push_t push,
  output logic              res_room,
  output logic              out_valid,
  input  logic              out_ready,
  output tlvaks_pkg::res_t  out_res
);
  import tlvaks_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

  res_t             mem [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             pop;

  assign out_valid = count_r != '0;
  assign out_res   = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign res_room  = count_r <= CNT_W'(RES_DEPTH - 2);
  assign count_nxt = count_r + CNT_W'(push.cnt) - CNT_W'(pop);

  // Up to two words are written in one cycle, in order.
  always_ff @(posedge clk) begin
    if (push.cnt == 2'd1) begin
      mem[wr_ptr_r] <= push.first;
    end else if (push.cnt == 2'd2) begin
      mem[wr_ptr_r]                   <= push.first;
      mem[PTR_W'(wr_ptr_r + 1'b1)]    <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= PTR_W'(wr_ptr_r + PTR_W'(push.cnt));
      rd_ptr_r <= PTR_W'(rd_ptr_r + PTR_W'(pop));
      count_r  <= count_nxt;
    end
  end

  // The queue never overfills.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  // Words arrive only while room for a pair was shown.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> res_room)
    else $error("result word pushed without room");

  // The count follows pushes and pops.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_nxt)))
    else $error("result count mismatch");

endmodule

@@ sim/tlv_address_key_search_checker.sv @@
`timescale 1ns / 1ps

// Watches the configuration, input and result channels of the key search.
// It keeps its own copy of the parse state, predicts the result words of
// every accepted input word and compares each result word with the oldest
// prediction.
module tlv_address_key_search_checker #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_first_byte,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       out_event_code,
  input  logic [63:0]                      out_value_high,
  input  logic [63:0]                      out_value_low,
  input  logic                             out_last_result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tlvaks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import tlvaks_pkg::*;

  // Key registers as the block should hold them.
  logic [63:0] want_hi, want_lo, len_hi, len_lo;

  // Parse state.
  phase_t                 phase;
  logic [OFFSET_BITS-1:0] blob_offset;
  logic [4:0]             field_cnt;
  logic [63:0]            key_sr;
  logic [31:0]            rec_size;
  logic [63:0]            total_len;
  logic [31:0]            data_left;
  logic                   key_hit;
  logic [63:0]            value_hi_hold;

  // Result words caused by the current input word, and those still due.
  res_t step_out[2];
  int   step_n;
  res_t due_events[$];

  int fails;

  task automatic emit_event(input logic [1:0] code, input logic [63:0] hi, lo);
    if (step_n < 2) begin
      step_out[step_n].code       = code;
      step_out[step_n].value_high = hi;
      step_out[step_n].value_low  = lo;
      step_out[step_n].last       = 1'b0;
      step_n++;
    end
  endtask

  task automatic begin_key(input phase_t next);
    phase     = next;
    field_cnt = '0;
    key_sr    = '0;
    key_hit   = 1'b0;
  endtask

  // At a record boundary the search ends unless a whole header still fits.
  task automatic record_end();
    if (64'(blob_offset) >= total_len ||
        total_len - 64'(blob_offset) < 64'(HDR_BYTES)) begin
      emit_event(EV_NO_MATCH, '0, '0);
      phase = PH_IDLE;
    end else begin
      begin_key(PH_RKEY);
    end
  endtask

  // Keys arrive first byte highest; each half is compared when complete.
  task automatic take_key_byte(input logic [7:0] b, input logic [63:0] hi, lo,
                               input phase_t next);
    key_sr = {key_sr[55:0], b};
    field_cnt++;
    if (field_cnt == KEY_HALF_BYTES) begin
      key_hit = (key_sr == hi);
      key_sr  = '0;
    end else if (field_cnt >= KEY_BYTES) begin
      key_hit   = key_hit && (key_sr == lo);
      key_sr    = '0;
      field_cnt = '0;
      rec_size  = '0;
      phase     = next;
    end
  endtask

  task automatic take_size_byte(input logic [7:0] b);
    rec_size = rec_size | (32'(b) << {field_cnt[1:0], 3'b000});
    field_cnt++;
  endtask

  // Advances the parse state by one input word and queues its result words.
  task automatic parse_byte(input logic [7:0] b, input logic first);
    step_n = 0;
    if (first) begin
      begin_key(PH_HKEY);
      blob_offset = '0;
      total_len   = '0;
    end
    if (first || phase != PH_IDLE) begin
      if (blob_offset != '1) blob_offset++;
      case (phase)
        PH_HKEY: take_key_byte(b, len_hi, len_lo, PH_HSIZE);
        PH_HSIZE: begin
          take_size_byte(b);
          if (field_cnt >= SIZE_BYTES) begin
            if (!key_hit || rec_size == '0) begin
              emit_event(EV_BAD_HDR, '0, '0);
              phase = PH_IDLE;
            end else begin
              data_left = rec_size;
              field_cnt = '0;
              total_len = '0;
              phase     = PH_HDATA;
            end
          end
        end
        PH_HDATA: begin
          // Only the first eight data bytes form the total length.
          if (field_cnt < LEN_BYTES) begin
            total_len = total_len | (64'(b) << {field_cnt[2:0], 3'b000});
            field_cnt++;
          end
          data_left--;
          if (data_left == '0) record_end();
        end
        PH_RKEY: take_key_byte(b, want_hi, want_lo, PH_RSIZE);
        PH_RSIZE: begin
          take_size_byte(b);
          if (field_cnt >= SIZE_BYTES) begin
            if (key_hit && rec_size == VALUE_SIZE) begin
              field_cnt = '0;
              key_sr    = '0;
              phase     = PH_RVAL;
            end else begin
              if (key_hit) emit_event(EV_MALFORMED, '0, '0);
              data_left = rec_size;
              if (data_left == '0) record_end();
              else phase = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          data_left--;
          if (data_left == '0) record_end();
        end
        PH_RVAL: begin
          // The value is taken whole, even past the total length.
          key_sr = {key_sr[55:0], b};
          field_cnt++;
          if (field_cnt == KEY_HALF_BYTES) begin
            value_hi_hold = key_sr;
            key_sr        = '0;
          end else if (field_cnt >= KEY_BYTES) begin
            emit_event(EV_FOUND, value_hi_hold, key_sr);
            phase = PH_IDLE;
          end
        end
        default: phase = PH_IDLE;
      endcase
      if (step_n > 0) step_out[step_n-1].last = 1'b1;
      for (int i = 0; i < step_n; i++) due_events.push_back(step_out[i]);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want, got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_event();
    res_t want;
    if (due_events.size() == 0) begin
      fails++;
      $display("%0t: result word with none expected, expected nothing, actual code %0d %0h %0h",
               $time, out_event_code, out_value_high, out_value_low);
    end else begin
      want = due_events.pop_front();
      compare_field("event_code", 64'(want.code), 64'(out_event_code));
      compare_field("value_high", want.value_high, out_value_high);
      compare_field("value_low", want.value_low, out_value_low);
      compare_field("last_result", 64'(want.last), 64'(out_last_result));
    end
  endtask

  // Sample every channel at the clock edge where its word is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      want_hi       = '0;
      want_lo       = '0;
      len_hi        = '0;
      len_lo        = '0;
      phase         = PH_IDLE;
      blob_offset   = '0;
      field_cnt     = '0;
      key_sr        = '0;
      rec_size      = '0;
      total_len     = '0;
      data_left     = '0;
      key_hit       = 1'b0;
      value_hi_hold = '0;
      due_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WANTED_KEY_HIGH: want_hi = cfg_data;
          REG_WANTED_KEY_LOW:  want_lo = cfg_data;
          REG_LENGTH_KEY_HIGH: len_hi  = cfg_data;
          REG_LENGTH_KEY_LOW:  len_lo  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_event();
      if (in_valid && in_ready) parse_byte(in_data_byte, in_first_byte);
    end
    fail_count <= fails;
    pending    <= due_events.size();
  end

endmodule

@@ sim/tlv_address_key_search_tb.sv @@
`timescale 1ns / 1ps

module tlv_address_key_search_tb;
  import tlvaks_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int TOTAL_BYTES   = 1450;
  localparam int SETTINGS_RUN  = 5;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 31;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic [7:0]           in_data_byte  = '0;
  logic                 in_first_byte = 1'b0;
  logic                 out_ready     = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [63:0]          cfg_data      = '0;

  logic        in_ready, out_valid, out_last_result, cfg_ready;
  logic [1:0]  out_event_code;
  logic [63:0] out_value_high, out_value_low;

  int fail_count, pending;
  int cycle_count = 0;
  int sent_count  = 0;

  // Stimulus controls shared by the sender and the receiver.
  logic calm      = 1'b0;
  logic hold_go   = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  // Keys currently programmed, used to build matching records.
  logic [63:0] key_want_hi, key_want_lo, key_len_hi, key_len_lo;

  logic [7:0] blob_bytes[$];

  tlv_address_key_search uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_first_byte   (in_first_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_code  (out_event_code),
    .out_value_high  (out_value_high),
    .out_value_low   (out_value_low),
    .out_last_result (out_last_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  tlv_address_key_search_checker key_search_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_first_byte   (in_first_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_code  (out_event_code),
    .out_value_high  (out_value_high),
    .out_value_low   (out_value_low),
    .out_last_result (out_last_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always #5 clk = ~clk;

  // Cycle counter and timeout.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** tlv_address_key_search: FAILED **");
    $finish;
  end

  // Result receiver: random stalls, a calm stretch, and long hold-offs on request.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offers one input word, idling at random first, and waits for its acceptance.
  task automatic send_byte(input logic [7:0] b, input logic first);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_first_byte <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_blob();
    foreach (blob_bytes[i]) send_byte(blob_bytes[i], i == 0);
    blob_bytes.delete();
  endtask

  task automatic add_key(input logic [63:0] hi, lo);
    for (int i = 7; i >= 0; i--) blob_bytes.push_back(hi[8*i +: 8]);
    for (int i = 7; i >= 0; i--) blob_bytes.push_back(lo[8*i +: 8]);
  endtask

  task automatic add_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) blob_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic add_random(input int n);
    repeat (n) blob_bytes.push_back(8'($urandom));
  endtask

  // Waits until every expected result word is out and the parser has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_keys(input logic [63:0] wh, wl, lh, ll);
    logic [63:0] vals[4];
    settle();
    vals = '{wh, wl, lh, ll};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid   <= 1'b0;
    key_want_hi = wh;
    key_want_lo = wl;
    key_len_hi  = lh;
    key_len_lo  = ll;
  endtask

  // Standard header of eight length bytes.
  task automatic add_header(input logic [63:0] total);
    add_key(key_len_hi, key_len_lo);
    add_le(64'd8, 4);
    add_le(total, 8);
  endtask

  task automatic run_directed();
    // Bytes without a first-byte mark while idle are ignored.
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    // Bad header through a key mismatch, then through a zero size.
    add_key(~key_len_hi, key_len_lo);
    add_le(64'd8, 4);
    send_blob();
    add_key(key_len_hi, key_len_lo);
    add_le(64'd0, 4);
    send_blob();
    // Header alone that ends exactly at the total length.
    add_header(64'd28);
    send_blob();
    // Long first record, then a found value with extreme bytes.
    add_key(key_len_hi, key_len_lo);
    add_le(64'd12, 4);
    add_le(64'd68, 8);
    add_random(4);
    add_key(key_want_hi, key_want_lo);
    add_le(64'd16, 4);
    add_le('1, 8);
    add_le('0, 8);
    send_blob();
    // Matching record of the wrong size, then a good one.
    add_header(64'd87);
    add_key(key_want_hi, key_want_lo);
    add_le(64'd3, 4);
    add_random(3);
    add_key(key_want_hi, key_want_lo);
    add_le(64'd16, 4);
    add_random(16);
    send_blob();
    // Zero-size matching record that also ends the blob.
    add_header(64'd48);
    add_key(key_want_hi, key_want_lo);
    add_le(64'd0, 4);
    send_blob();
    // Matching value that lies past the total length.
    add_header(64'd48);
    add_key(key_want_hi, key_want_lo);
    add_le(64'd16, 4);
    add_random(16);
    send_blob();
    // Restart in the middle of a record.
    add_header(64'd200);
    add_random(10);
    send_blob();
    add_header(64'd28);
    send_blob();
    // Half-matching key, then too few bytes left for another header.
    add_header(64'd60);
    add_key(key_want_hi, ~key_want_lo);
    add_le(64'd2, 4);
    add_random(2);
    add_key(~key_want_hi, key_want_lo);
    add_le(64'd0, 4);
    send_blob();
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0:          return 32'd0;
      1, 2, 3, 4: return 32'd16;
      9:          return 32'($urandom_range(9, 40));
      default:    return 32'($urandom_range(1, 8));
    endcase
  endfunction

  // Builds a mostly well-formed blob with random content and sends it.
  task automatic send_random_blob();
    int          pick;
    int          hdr_size;
    int          cut;
    logic [31:0] sz;
    logic [63:0] khi, klo, total;
    blob_bytes.delete();
    pick = $urandom_range(0, 15);
    if (pick == 0) add_key(key_len_hi ^ (64'd1 << $urandom_range(0, 63)), key_len_lo);
    else if (pick == 1) add_key(key_len_hi, rand_word());
    else add_key(key_len_hi, key_len_lo);
    pick = $urandom_range(0, 15);
    if (pick == 0) hdr_size = 0;
    else if (pick < 12) hdr_size = 8;
    else hdr_size = $urandom_range(1, 12);
    add_le(64'(hdr_size), 4);
    add_random(hdr_size);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin khi = key_want_hi; klo = key_want_lo; end
        3:       begin khi = key_want_hi; klo = rand_word(); end
        4:       begin khi = rand_word(); klo = key_want_lo; end
        5:       begin khi = key_len_hi; klo = key_len_lo; end
        default: begin khi = rand_word(); klo = rand_word(); end
      endcase
      sz = rand_size();
      if ($urandom_range(0, 49) == 0) sz = sz | (32'd1 << $urandom_range(8, 31));
      add_key(khi, klo);
      add_le(64'(sz), 4);
      add_random(sz > 32'd40 ? $urandom_range(0, 10) : int'(sz));
    end
    // Total length: mostly exact, sometimes short, long or arbitrary.
    total = 64'(blob_bytes.size());
    case ($urandom_range(0, 9))
      0:       total = rand_word();
      1:       total = total - 64'($urandom_range(0, 30));
      2:       total = total + 64'($urandom_range(1, 40));
      default: ;
    endcase
    for (int i = 0; i < hdr_size && i < 8; i++) blob_bytes[20+i] = total[8*i +: 8];
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, blob_bytes.size());
      while (blob_bytes.size() > cut) blob_bytes.delete(blob_bytes.size() - 1);
    end
    send_blob();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
  endtask

  // Main stimulus: reset, key settings, directed blobs, random blobs, verdict.
  initial begin
    int          goal;
    logic [63:0] kh, kl;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int setting = 0; setting < SETTINGS_RUN; setting++) begin
      case (setting)
        0: set_keys(rand_word(), rand_word(), rand_word(), rand_word());
        1: set_keys('0, '0, '0, '0);
        2: set_keys('1, '1, '1, '1);
        3: begin
          kh = rand_word();
          kl = rand_word();
          set_keys(kh, kl, kh, kl);
        end
        default: set_keys(rand_word(), rand_word(), rand_word(), rand_word());
      endcase
      if (setting == 0) run_directed();
      if (setting == 1 || setting == 3) hold_go <= ~hold_go;
      calm = (setting == 2);
      goal = (TOTAL_BYTES * (setting + 1)) / SETTINGS_RUN;
      while (sent_count < goal) begin
        send_random_blob();
        if ($urandom_range(0, 7) == 0) send_noise();
      end
      calm = 1'b0;
    end
    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("** tlv_address_key_search: PASSED **");
    end else begin
      $display("** tlv_address_key_search: FAILED **");
    end
    $finish;
  end

endmodule
